FILE: rtl/sensor_reading_seven_segment_display_macros.svh
// ----------------------------------------------------------------------------
// Sensor display assertion macros
// Shared property wrappers for the display checker.
// ----------------------------------------------------------------------------
`ifndef SENSOR_READING_SEVEN_SEGMENT_DISPLAY_MACROS_SVH
`define SENSOR_READING_SEVEN_SEGMENT_DISPLAY_MACROS_SVH

// Property checked only outside reset.
`define SRSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define SRSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/srsd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor display package
// Types, codes, segment tables and fixed-point helpers for the display block.
// ----------------------------------------------------------------------------
package srsd_pkg;

  localparam int RAW_W   = 16;
  localparam int TENTH_W = 11;
  localparam int DIGS_W  = 12;

  // Configuration register indexes
  localparam logic [1:0] CFG_DWELL    = 2'd0;
  localparam logic [1:0] CFG_PHASE    = 2'd1;
  localparam logic [1:0] CFG_GAP_TEMP = 2'd2;
  localparam logic [1:0] CFG_GAP_HUM  = 2'd3;

  localparam logic [7:0]  DWELL_RESET    = 8'd5;
  localparam logic [15:0] PHASE_RESET    = 16'd3000;
  localparam logic [15:0] GAP_TEMP_RESET = 16'd200;
  localparam logic [15:0] GAP_HUM_RESET  = 16'd500;

  // Showing codes
  localparam logic [1:0] SHOW_TEMP  = 2'd0;
  localparam logic [1:0] SHOW_HUM   = 2'd1;
  localparam logic [1:0] SHOW_BLANK = 2'd2;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_SYM_C = 8'h58;
  localparam logic [7:0] SEG_SYM_H = 8'h76;

  localparam logic [10:0] TEMP_SCALE  = 11'd1750;
  localparam logic [10:0] HUM_SCALE   = 11'd1000;
  localparam logic [10:0] TEMP_OFFSET = 11'd450;

  typedef struct packed {
    logic load_in;
    logic load_val;
  } conv_ctl_t;

  typedef struct packed {
    logic               command;
    logic [TENTH_W-1:0] temp_tenths;
    logic [TENTH_W-1:0] hum_tenths;
  } conv_out_t;

  // floor(x / 65535) for x below 2^27: estimate low, then one correction.
  function automatic logic [TENTH_W-1:0] div_by_65535(input logic [27:0] x);
    logic [27:0] est_sum;
    logic [11:0] q;
    logic [27:0] rem;
    est_sum = x + {16'd0, x[27:16]};
    q       = est_sum[27:16];
    rem     = x - {q, 16'd0} + {16'd0, q};
    if (rem >= 28'd65535) begin
      q = q + 12'd1;
    end
    return q[TENTH_W-1:0];
  endfunction

  // Tens, units, tenths of a value up to 1300, each mod 10.
  function automatic logic [DIGS_W-1:0] pack_digits(input logic [TENTH_W-1:0] v);
    logic [23:0] p100;
    logic [23:0] p10;
    logic [3:0]  hundreds;
    logic [7:0]  tens_all;
    logic [3:0]  d_tens;
    logic [7:0]  d_units;
    logic [10:0] d_tenths;
    p100     = {13'd0, v} * 24'd5243;
    p10      = {13'd0, v} * 24'd6554;
    hundreds = p100[22:19];
    tens_all = p10[23:16];
    d_tens   = (hundreds >= 4'd10) ? hundreds - 4'd10 : hundreds;
    d_units  = tens_all - ({1'b0, hundreds, 3'b000} + {3'b000, hundreds, 1'b0});
    d_tenths = v - ({tens_all, 3'b000} + {2'b00, tens_all, 1'b0});
    return {d_tens, d_units[3:0], d_tenths[3:0]};
  endfunction

  function automatic logic [7:0] seg_of_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/srsd_conv.sv
// ----------------------------------------------------------------------------
// Sensor word converter
// Two register stages: request capture, then scaled values in tenths.
// ----------------------------------------------------------------------------
module srsd_conv (
  input  logic                                clk,
  input  srsd_pkg::conv_ctl_t                 ctl,
  input  logic                                command,
  input  logic [srsd_pkg::RAW_W-1:0]          raw_temperature,
  input  logic [srsd_pkg::RAW_W-1:0]          raw_humidity,
  output srsd_pkg::conv_out_t                 result
);
  import srsd_pkg::*;

  logic             in_command;
  logic [RAW_W-1:0] in_raw_t;
  logic [RAW_W-1:0] in_raw_h;
  logic [27:0]      t_prod;
  logic [27:0]      h_prod;
  logic [TENTH_W-1:0] t_q;
  logic [TENTH_W-1:0] h_q;
  conv_out_t        val_next;
  conv_out_t        val;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      in_command <= command;
      in_raw_t   <= raw_temperature;
      in_raw_h   <= raw_humidity;
    end
    if (ctl.load_val) begin
      val <= val_next;
    end
  end

  always_comb begin
    t_prod = {12'd0, in_raw_t} * {17'd0, TEMP_SCALE};
    h_prod = {12'd0, in_raw_h} * {17'd0, HUM_SCALE};
    t_q    = div_by_65535(t_prod);
    h_q    = div_by_65535(h_prod);
    val_next.command     = in_command;
    // clamp below-range temperatures to zero
    val_next.temp_tenths = (t_q >= TEMP_OFFSET) ? t_q - TEMP_OFFSET : '0;
    val_next.hum_tenths  = h_q;
  end

  assign result = val;

endmodule

FILE: rtl/sensor_reading_seven_segment_display.sv
// ----------------------------------------------------------------------------
// Sensor reading seven-segment display: a request's result passes the input register, the conversion
// register and the result register. One request per cycle while in_stall is low.
// Synchronous reset clears pipeline valids, digits and scan state, and loads register defaults.
// ----------------------------------------------------------------------------
module sensor_reading_seven_segment_display (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [srsd_pkg::RAW_W-1:0] raw_temperature,
  input  logic [srsd_pkg::RAW_W-1:0] raw_humidity,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 digit_enable_n,
  output logic [7:0]                 segments,
  output logic [1:0]                 showing,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);
  import srsd_pkg::*;

  typedef enum logic [1:0] {PH_TEMP, PH_GAP_T, PH_HUM, PH_GAP_H} phase_t;

  // configuration
  logic [7:0]  digit_dwell_ticks;
  logic [15:0] phase_ticks;
  logic [15:0] gap_after_temp_ticks;
  logic [15:0] gap_after_hum_ticks;

  // pipeline control
  logic      in_full;
  logic      val_full;
  logic      adv_out;
  logic      adv_val;
  logic      adv_in;
  conv_ctl_t ctl;
  conv_out_t conv;

  // display state
  phase_t            phase, phase_next;
  logic [15:0]       phase_count, phase_count_next;
  logic [7:0]        dwell_count, dwell_count_next;
  logic [1:0]        digit_index, digit_index_next;
  logic [DIGS_W-1:0] temperature_digits, temperature_digits_next;
  logic [DIGS_W-1:0] humidity_digits, humidity_digits_next;

  logic [15:0]       pc_inc;
  logic [7:0]        dwell_inc;
  logic [DIGS_W-1:0] cur_digits;
  logic [3:0]        nib;
  logic [3:0]        enable_n_next;
  logic [7:0]        segments_next;
  logic [1:0]        showing_next;

  assign adv_out   = !out_valid || !out_stall;
  assign adv_val   = !val_full || adv_out;
  assign adv_in    = !in_full || adv_val;
  assign in_stall  = !adv_in;
  assign ctl.load_in  = adv_in;
  assign ctl.load_val = adv_val;
  assign cfg_ready = 1'b1;

  srsd_conv u_conv (
    .clk             (clk),
    .ctl             (ctl),
    .command         (command),
    .raw_temperature (raw_temperature),
    .raw_humidity    (raw_humidity),
    .result          (conv)
  );

  // Result for the current state, with fresh digits on a sample request
  always_comb begin
    temperature_digits_next = temperature_digits;
    humidity_digits_next    = humidity_digits;
    if (conv.command) begin
      temperature_digits_next = pack_digits(conv.temp_tenths);
      humidity_digits_next    = pack_digits(conv.hum_tenths);
    end

    cur_digits = (phase == PH_TEMP) ? temperature_digits_next : humidity_digits_next;
    case (digit_index)
      2'd0:    nib = cur_digits[11:8];
      2'd1:    nib = cur_digits[7:4];
      default: nib = cur_digits[3:0];
    endcase

    if (phase == PH_GAP_T || phase == PH_GAP_H) begin
      enable_n_next = 4'hF;
      segments_next = SEG_BLANK;
      showing_next  = SHOW_BLANK;
    end else begin
      enable_n_next = ~(4'b0001 << digit_index);
      if (digit_index == 2'd3) begin
        segments_next = (phase == PH_TEMP) ? SEG_SYM_C : SEG_SYM_H;
      end else begin
        segments_next = seg_of_digit(nib);
      end
      showing_next = (phase == PH_TEMP) ? SHOW_TEMP : SHOW_HUM;
    end
  end

  // Scan and phase sequencing for a tick request
  always_comb begin
    phase_next       = phase;
    phase_count_next = phase_count;
    dwell_count_next = dwell_count;
    digit_index_next = digit_index;
    pc_inc    = (phase_count == 16'hFFFF) ? phase_count : phase_count + 16'd1;
    dwell_inc = dwell_count + 8'd1;

    if (!conv.command) begin
      case (phase)
        PH_GAP_T, PH_GAP_H: begin
          if (pc_inc >= ((phase == PH_GAP_T) ? gap_after_temp_ticks
                                             : gap_after_hum_ticks)) begin
            phase_next       = (phase == PH_GAP_T) ? PH_HUM : PH_TEMP;
            phase_count_next = '0;
            dwell_count_next = '0;
            digit_index_next = '0;
          end else begin
            phase_count_next = pc_inc;
          end
        end
        PH_TEMP, PH_HUM: begin
          phase_count_next = pc_inc;
          if (dwell_inc >= digit_dwell_ticks) begin
            dwell_count_next = '0;
            if (digit_index == 2'd3) begin
              digit_index_next = '0;
              // end the phase only at a scan boundary
              if (pc_inc >= phase_ticks) begin
                if (phase == PH_TEMP) begin
                  phase_next = (gap_after_temp_ticks == '0) ? PH_HUM : PH_GAP_T;
                end else begin
                  phase_next = (gap_after_hum_ticks == '0) ? PH_TEMP : PH_GAP_H;
                end
                phase_count_next = '0;
              end
            end else begin
              digit_index_next = digit_index + 2'd1;
            end
          end else begin
            dwell_count_next = dwell_inc;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full              <= 1'b0;
      val_full             <= 1'b0;
      out_valid            <= 1'b0;
      phase                <= PH_TEMP;
      phase_count          <= '0;
      dwell_count          <= '0;
      digit_index          <= '0;
      temperature_digits   <= '0;
      humidity_digits      <= '0;
      digit_dwell_ticks    <= DWELL_RESET;
      phase_ticks          <= PHASE_RESET;
      gap_after_temp_ticks <= GAP_TEMP_RESET;
      gap_after_hum_ticks  <= GAP_HUM_RESET;
    end else begin
      if (adv_in) begin
        in_full <= in_valid;
      end
      if (adv_val) begin
        val_full <= in_full;
      end
      if (adv_out) begin
        out_valid <= val_full;
        if (val_full) begin
          phase              <= phase_next;
          phase_count        <= phase_count_next;
          dwell_count        <= dwell_count_next;
          digit_index        <= digit_index_next;
          temperature_digits <= temperature_digits_next;
          humidity_digits    <= humidity_digits_next;
          digit_enable_n     <= enable_n_next;
          segments           <= segments_next;
          showing            <= showing_next;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DWELL:    digit_dwell_ticks    <= cfg_data[7:0];
          CFG_PHASE:    phase_ticks          <= cfg_data;
          CFG_GAP_TEMP: gap_after_temp_ticks <= cfg_data;
          CFG_GAP_HUM:  gap_after_hum_ticks  <= cfg_data;
          default:      digit_dwell_ticks    <= digit_dwell_ticks;
        endcase
      end
    end
  end

endmodule

FILE: rtl/srsd_checker.sv
// ----------------------------------------------------------------------------
// Sensor display port checker
// Watches the result channel of the display block.
// ----------------------------------------------------------------------------
`include "sensor_reading_seven_segment_display_macros.svh"

module srsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] digit_enable_n,
  input logic [7:0] segments,
  input logic [1:0] showing
);
  import srsd_pkg::*;

  // hold a stalled result
  `SRSD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(segments) && $stable(digit_enable_n) && $stable(showing), "stalled result changed")
  `SRSD_ASSERT(a_blank_dark, out_valid && showing == SHOW_BLANK |-> digit_enable_n == 4'hF && segments == SEG_BLANK, "blank gap drives segments")
  `SRSD_ASSERT(a_one_digit, out_valid && showing != SHOW_BLANK |-> $onehot(~digit_enable_n) && showing != 2'd3, "lit phase must enable exactly one digit")
  `SRSD_ASSERT(a_dp_off, out_valid |-> !segments[7], "decimal point lit")
  `SRSD_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result valid after reset")

endmodule

bind sensor_reading_seven_segment_display srsd_checker u_srsd_checker (.*);

FILE: dv/sensor_reading_seven_segment_display_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor display regression
// Streams tick and sample requests into the display driver under random
// stalls on both sides, predicts every frame with a local scan model and
// compares enables, segments and showing code field by field.
// ----------------------------------------------------------------------------
module sensor_reading_seven_segment_display_test;
  import srsd_pkg::*;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;
  localparam int   CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {
    PH_TEMP  = 2'd0,
    PH_GAP_T = 2'd1,
    PH_HUM   = 2'd2,
    PH_GAP_H = 2'd3
  } scan_phase_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] rt;
    logic [15:0] rh;
  } stim_t;

  typedef struct packed {
    logic [3:0] enables;
    logic [7:0] seg;
    logic [1:0] show;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_TICK;
  logic [15:0] raw_temperature = 16'd0;
  logic [15:0] raw_humidity = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  digit_enable_n;
  logic [7:0]  segments;
  logic [1:0]  showing;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_DWELL;
  logic [15:0] cfg_data = 16'd0;

  // Scan model state and its copy of the registers
  logic [7:0]  dwell_cfg;
  logic [15:0] phase_cfg;
  logic [15:0] gap_t_cfg;
  logic [15:0] gap_h_cfg;
  logic [11:0] temp_digs;
  logic [11:0] hum_digs;
  scan_phase_t phase;
  logic [15:0] ph_count;
  logic [7:0]  dwell_cnt;
  logic [1:0]  digit_idx;

  logic [7:0] digit_glyph [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                   8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  stim_t  stim_q[$];
  frame_t frame_q[$];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_samples = 0;
  int  n_ticks = 0;
  int  n_frames = 0;
  int  n_cfg_writes = 0;
  int  n_settings = 0;
  int  errors = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  in_taken = 1'b0;
  bit  hold_req = 1'b0;
  bit  calm = 1'b0;

  sensor_reading_seven_segment_display u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .raw_temperature (raw_temperature),
    .raw_humidity    (raw_humidity),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digit_enable_n  (digit_enable_n),
    .segments        (segments),
    .showing         (showing),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [11:0] to_digits(input int unsigned v);
    logic [3:0] d_tens;
    logic [3:0] d_units;
    logic [3:0] d_tenths;
    d_tens   = 4'((v / 100) % 10);
    d_units  = 4'((v / 10) % 10);
    d_tenths = 4'(v % 10);
    return {d_tens, d_units, d_tenths};
  endfunction

  function automatic void enter_phase(input scan_phase_t p);
    phase     = p;
    ph_count  = 16'd0;
    dwell_cnt = 8'd0;
    digit_idx = 2'd0;
  endfunction

  function automatic frame_t display_view();
    frame_t      f;
    logic [11:0] digs;
    logic [3:0]  nib;
    if (phase == PH_GAP_T || phase == PH_GAP_H) begin
      f.enables = 4'hF;
      f.seg     = SEG_BLANK;
      f.show    = SHOW_BLANK;
    end else begin
      digs = (phase == PH_TEMP) ? temp_digs : hum_digs;
      case (digit_idx)
        2'd0: begin
          nib = digs[11:8];
        end
        2'd1: begin
          nib = digs[7:4];
        end
        default: begin
          nib = digs[3:0];
        end
      endcase
      if (digit_idx == 2'd3) begin
        f.seg = (phase == PH_TEMP) ? SEG_SYM_C : SEG_SYM_H;
      end else begin
        f.seg = (nib < 4'd10) ? digit_glyph[nib] : SEG_BLANK;
      end
      f.enables = ~(4'b0001 << digit_idx);
      f.show    = (phase == PH_TEMP) ? SHOW_TEMP : SHOW_HUM;
    end
    return f;
  endfunction

  // Advance the scan model by one request and return the frame it shows
  function automatic frame_t scan_step(input stim_t s);
    frame_t      f;
    int unsigned t;
    int unsigned h;
    logic [15:0] gap_len;
    if (s.cmd == CMD_SAMPLE) begin
      t = {16'd0, s.rt};
      t = t * 1750 / 65535;
      h = {16'd0, s.rh};
      h = h * 1000 / 65535;
      if (t >= 450) begin
        t = t - 450;
      end else begin
        t = 0;
      end
      temp_digs = to_digits(t);
      hum_digs  = to_digits(h);
      f = display_view();
    end else begin
      f = display_view();
      if (ph_count != 16'hFFFF) begin
        ph_count = ph_count + 16'd1;
      end
      if (phase == PH_GAP_T || phase == PH_GAP_H) begin
        gap_len = (phase == PH_GAP_T) ? gap_t_cfg : gap_h_cfg;
        if (ph_count >= gap_len) begin
          if (phase == PH_GAP_T) begin
            enter_phase(PH_HUM);
          end else begin
            enter_phase(PH_TEMP);
          end
        end
      end else begin
        dwell_cnt = dwell_cnt + 8'd1;
        if (dwell_cnt >= dwell_cfg) begin
          dwell_cnt = 8'd0;
          if (digit_idx == 2'd3) begin
            digit_idx = 2'd0;
            // leave the display phase only at a scan boundary
            if (ph_count >= phase_cfg) begin
              if (phase == PH_TEMP) begin
                if (gap_t_cfg == 16'd0) begin
                  enter_phase(PH_HUM);
                end else begin
                  enter_phase(PH_GAP_T);
                end
              end else begin
                if (gap_h_cfg == 16'd0) begin
                  enter_phase(PH_TEMP);
                end else begin
                  enter_phase(PH_GAP_H);
                end
              end
            end
          end else begin
            digit_idx = digit_idx + 2'd1;
          end
        end
      end
    end
    return f;
  endfunction

  // Request side: hold a stalled request, otherwise idle or advance
  always @(negedge clk) begin
    stim_t s;
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        s = stim_q.pop_front();
        in_valid        <= 1'b1;
        command         <= s.cmd;
        raw_temperature <= s.rt;
        raw_humidity    <= s.rh;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted request
  always @(posedge clk) begin
    stim_t s;
    if (!rst && in_valid && !in_stall) begin
      s.cmd = command;
      s.rt  = raw_temperature;
      s.rh  = raw_humidity;
      frame_q.push_back(scan_step(s));
      if (command == CMD_SAMPLE) begin
        n_samples++;
      end else begin
        n_ticks++;
      end
      n_accepted++;
      in_taken = 1'b1;
    end
  end

  // Result side stall: long hold-off on request, short random bursts otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 299;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frame_t f;
    if (!rst && out_valid && !out_stall) begin
      n_frames++;
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h/%h/%h", $time,
                 digit_enable_n, segments, showing);
        errors++;
      end else begin
        f = frame_q.pop_front();
        report_field("digit_enable_n", {4'd0, f.enables}, {4'd0, digit_enable_n});
        report_field("segments", f.seg, segments);
        report_field("showing", {6'd0, f.show}, {6'd0, showing});
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, frame_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DWELL: begin
        dwell_cfg = data[7:0];
      end
      CFG_PHASE: begin
        phase_cfg = data;
      end
      CFG_GAP_TEMP: begin
        gap_t_cfg = data;
      end
      default: begin
        gap_h_cfg = data;
      end
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] dwell, input logic [15:0] len,
                            input logic [15:0] gap_t, input logic [15:0] gap_h);
    cfg_write(CFG_DWELL, dwell);
    cfg_write(CFG_PHASE, len);
    cfg_write(CFG_GAP_TEMP, gap_t);
    cfg_write(CFG_GAP_HUM, gap_h);
    n_settings++;
  endtask

  task automatic push_item(input logic cmd, input logic [15:0] rt, input logic [15:0] rh);
    stim_t s;
    s.cmd = cmd;
    s.rt  = rt;
    s.rh  = rh;
    stim_q.push_back(s);
    n_queued++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      push_item(CMD_TICK, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        push_item(CMD_SAMPLE, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
      end else begin
        push_item(CMD_TICK, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic drain();
    while (n_accepted != n_queued || frame_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    logic [15:0] gt;
    logic [15:0] gh;
    dwell_cfg = DWELL_RESET;
    phase_cfg = PHASE_RESET;
    gap_t_cfg = GAP_TEMP_RESET;
    gap_h_cfg = GAP_HUM_RESET;
    temp_digs = 12'd0;
    hum_digs  = 12'd0;
    enter_phase(PH_TEMP);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: range ends, the clamp threshold and odd bit patterns
    push_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
    push_ticks(3);
    push_item(CMD_SAMPLE, 16'h0000, 16'h0000);
    push_ticks(4);
    push_item(CMD_SAMPLE, 16'hFFFF, 16'hFFFF);
    push_ticks(5);
    push_item(CMD_SAMPLE, 16'd16852, 16'd32768);
    push_item(CMD_SAMPLE, 16'd16853, 16'd65534);
    push_ticks(3);
    push_item(CMD_SAMPLE, 16'hAAAA, 16'h5555);
    push_item(CMD_SAMPLE, 16'h5555, 16'hAAAA);
    push_ticks(5);
    drain();

    // Zero dwell, zero phase length and both gaps skipped
    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    push_item(CMD_SAMPLE, 16'd40000, 16'd20000);
    push_ticks(40);
    drain();

    set_config(16'd1, 16'd1, 16'd1, 16'd1);
    push_item(CMD_SAMPLE, 16'd30000, 16'd50000);
    push_ticks(50);
    drain();

    // Register maxima: upper dwell bits dropped, first digit held for the whole burst
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(CMD_SAMPLE, 16'd60000, 16'd10000);
    push_ticks(40);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        calm = 1'b1;
      end
      gt = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 20));
      gh = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 20));
      set_config({8'($urandom_range(0, 255)), 8'($urandom_range(0, 3))},
                 16'($urandom_range(0, 30)), gt, gh);
      push_random(125);
      // fill the pipe against a stalled receiver
      if (p == 3) begin
        hold_req = 1'b1;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (frame_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, frame_q.size());
      errors++;
    end
    $display("Covered %0d ticks and %0d samples over %0d register settings (%0d writes).",
             n_ticks, n_samples, n_settings, n_cfg_writes);
    $display("Checked %0d frames, %0d mismatches.", n_frames, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/srsd_pkg.sv
rtl/srsd_conv.sv
rtl/sensor_reading_seven_segment_display.sv
rtl/srsd_checker.sv
dv/sensor_reading_seven_segment_display_test.sv
